FILE: design/mfqs_pkg.sv
// Shared types and codes for the four-level feedback queue scheduler.
`default_nettype none
package mfqs_pkg;
   localparam int NUM_LEVELS = 4;
   localparam logic [0:0] FUNC_ARRIVE = 1'b0;
   localparam logic [0:0] FUNC_TICK = 1'b1;
   localparam logic [2:0] EV_IDLE = 3'd0;
   localparam logic [2:0] EV_KEPT = 3'd1;
   localparam logic [2:0] EV_FINISHED = 3'd2;
   localparam logic [2:0] EV_DEMOTED = 3'd3;
   localparam logic [2:0] EV_PREEMPT = 3'd4;
   localparam logic [2:0] EV_ROTATE = 3'd5;
   localparam logic [2:0] EV_ACCEPTED = 3'd6;
   localparam logic [2:0] EV_DROPPED = 3'd7;
   localparam logic [1:0] REG_L2 = 2'd0;
   localparam logic [1:0] REG_L3 = 2'd1;
   localparam logic [1:0] REG_L4 = 2'd2;
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_OUT  = 3'b100
   } state_type;
endpackage
`default_nettype wire

FILE: design/mfqs_if.sv
// Valid/ready channel interfaces for the scheduler.
`default_nettype none
interface mfqs_req_if;
   logic       valid;
   logic       ready;
   logic [0:0] func;
   logic [3:0] task_id;
   logic [7:0] task_life;
   modport source (output valid, func, task_id, task_life, input ready);
   modport sink (input valid, func, task_id, task_life, output ready);
endinterface

interface mfqs_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] served_id;
   logic [2:0] served_level;
   logic [2:0] event_res;
   modport source (output valid, served_id, served_level, event_res, input ready);
   modport sink (input valid, served_id, served_level, event_res, output ready);
endinterface
`default_nettype wire

FILE: design/multilevel_feedback_queue_scheduler.sv
// Top level of the four-level feedback queue scheduler.
// An item is accepted only in the idle state. Acceptance reads the head slot of the queue memory,
// the READ state reads the task memory, and the OUT state computes, writes back and loads the
// result register. A new item is taken only once the OUT state has gone back to idle, so items
// do not overlap. The compute stage holds its item while the result register still carries an
// untaken result. Queue pointers and active bits are registers; queue rings and per-task age,
// life and counters are memories.
`default_nettype none
module multilevel_feedback_queue_scheduler #(
   parameter int MAX_TASKS = 16
) (
   input  wire        clock,
   input  wire        reset,
   mfqs_req_if.sink   req,
   mfqs_rsp_if.source rsp,
   input  wire        csr_psel,
   input  wire        csr_penable,
   input  wire        csr_pwrite,
   input  wire [3:0]  csr_paddr,
   input  wire [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic       csr_pready
);
   localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int QD = mfqs_pkg::NUM_LEVELS * MAX_TASKS;
   localparam int QW = $clog2(QD);

   logic [TW-1:0] qmem [QD];
   logic [31:0]   tmem [MAX_TASKS];

   logic [7:0] bud2_ff, bud3_ff, bud4_ff;
   logic [TW-1:0] head_ff [mfqs_pkg::NUM_LEVELS];
   logic [CW-1:0] cnt_ff [mfqs_pkg::NUM_LEVELS];
   logic [MAX_TASKS-1:0] act_ff;
   logic [2:0] ptr_ff;
   mfqs_pkg::state_type st_ff;
   logic [0:0] func_ff;
   logic [3:0] id_ff;
   logic [7:0] life_ff;
   logic [1:0] lvl_ff;
   logic       any_ff;
   logic [TW-1:0] qrd_ff;
   logic [31:0] trd_ff;
   logic [3:0] oid_ff;
   logic [2:0] olvl_ff, oev_ff;
   logic       rsp_v_ff;
   logic       advance;

   // level-4 counters kept in a separate memory
   logic [7:0] l4mem [MAX_TASKS];
   logic [7:0] l4rd_ff, l4_n;
   assign l4_n = (lvl_ff == 2'd3) ? (l4rd_ff == 8'hff ? 8'hff : l4rd_ff + 8'd1)
                                  : l4rd_ff;

   // pointer scan
   logic [2:0] p0;
   logic [1:0] scan_lvl;
   logic       scan_any;
   always_comb begin
      p0 = (ptr_ff == 3'd0 || ptr_ff > 3'd4) ? 3'd1 : ptr_ff;
      scan_any = 1'b0;
      scan_lvl = 2'd0;
      for (int k = mfqs_pkg::NUM_LEVELS - 1; k >= 0; k--) begin
         if (3'(k + 1) >= p0 && cnt_ff[k] != '0) begin
            scan_any = 1'b1;
            scan_lvl = 2'(k);
         end
      end
   end

   logic accept_req;
   assign req.ready = st_ff == mfqs_pkg::ST_IDLE;
   assign accept_req = req.valid && req.ready;
   assign advance = st_ff == mfqs_pkg::ST_OUT && (!rsp_v_ff || rsp.ready);

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[3:2])
         mfqs_pkg::REG_L2: csr_prdata = {24'd0, bud2_ff};
         mfqs_pkg::REG_L3: csr_prdata = {24'd0, bud3_ff};
         mfqs_pkg::REG_L4: csr_prdata = {24'd0, bud4_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   // compute stage
   logic [TW-1:0] t;
   logic [7:0] age_n, c2, c3, cnt_sel, budget;
   logic higher, finished, do_pop, do_push, id_ok;
   logic [1:0] push_lvl;
   logic [TW-1:0] push_id;
   logic [2:0] ev;
   logic [2:0] ptr_n;
   logic tw_en;
   logic [31:0] tw_data;
   logic [TW-1:0] tw_addr;
   always_comb begin
      t = qrd_ff;
      age_n = trd_ff[7:0] == 8'hff ? 8'hff : trd_ff[7:0] + 8'd1;
      c2 = trd_ff[23:16];
      c3 = trd_ff[31:24];
      higher = 1'b0;
      for (int k = 0; k < mfqs_pkg::NUM_LEVELS - 1; k++) begin
         if (2'(k) < lvl_ff && cnt_ff[k] != '0) higher = 1'b1;
      end
      cnt_sel = 8'd0;
      budget = bud4_ff;
      do_pop = 1'b0;
      do_push = 1'b0;
      push_lvl = lvl_ff;
      push_id = t;
      ev = mfqs_pkg::EV_KEPT;
      ptr_n = ptr_ff;
      tw_en = 1'b0;
      tw_addr = t;
      tw_data = trd_ff;
      id_ok = 1'b0;
      finished = 1'b0;
      if (func_ff == mfqs_pkg::FUNC_ARRIVE) begin
         id_ok = (32'(id_ff) < MAX_TASKS) && !act_ff[TW'(id_ff)] &&
                 (32'(cnt_ff[0]) < MAX_TASKS);
         ev = id_ok ? mfqs_pkg::EV_ACCEPTED : mfqs_pkg::EV_DROPPED;
         do_push = id_ok;
         push_lvl = 2'd0;
         push_id = TW'(id_ff);
         tw_en = id_ok;
         tw_addr = TW'(id_ff);
         tw_data = {16'd0, life_ff, 8'd0};
      end else if (!any_ff) begin
         ev = mfqs_pkg::EV_IDLE;
         ptr_n = 3'd0;
      end else begin
         ptr_n = {1'b0, lvl_ff} + 3'd1;
         case (lvl_ff)
            2'd1: begin
               c2 = c2 == 8'hff ? 8'hff : c2 + 8'd1;
               cnt_sel = c2;
               budget = bud2_ff;
            end
            2'd2: begin
               c3 = c3 == 8'hff ? 8'hff : c3 + 8'd1;
               cnt_sel = c3;
               budget = bud3_ff;
            end
            default: ;
         endcase
         tw_en = 1'b1;
         finished = age_n >= trd_ff[15:8];
         if (finished) begin
            do_pop = 1'b1;
            ev = mfqs_pkg::EV_FINISHED;
         end else if (lvl_ff == 2'd0) begin
            do_pop = 1'b1;
            do_push = 1'b1;
            push_lvl = 2'd1;
            ev = mfqs_pkg::EV_DEMOTED;
         end else if (lvl_ff != 2'd3) begin
            if (cnt_sel < budget) begin
               if (higher) begin
                  do_pop = 1'b1;
                  do_push = 1'b1;
                  ptr_n = 3'd1;
                  ev = mfqs_pkg::EV_PREEMPT;
               end
            end else begin
               do_pop = 1'b1;
               do_push = 1'b1;
               push_lvl = lvl_ff + 2'd1;
               ev = mfqs_pkg::EV_DEMOTED;
            end
         end else begin
            if (higher) begin
               do_pop = 1'b1;
               do_push = 1'b1;
               ptr_n = 3'd1;
               ev = mfqs_pkg::EV_PREEMPT;
            end else if (l4_n >= bud4_ff) begin
               do_pop = 1'b1;
               do_push = 1'b1;
               ev = mfqs_pkg::EV_ROTATE;
            end
         end
         tw_data = {c3, c2, trd_ff[15:8], age_n};
      end
   end

   // queue slot addresses; a pop at the push level moves the head by one and leaves the count unchanged
   logic [QW-1:0] head_addr, push_addr;
   logic [CW:0] pos;
   logic [TW-1:0] pos_w;
   always_comb begin
      head_addr = QW'(32'(scan_lvl) * MAX_TASKS + 32'(head_ff[scan_lvl]));
      pos = {1'b0, cnt_ff[push_lvl]} + (CW + 1)'(head_ff[push_lvl]);
      if (32'(pos) >= MAX_TASKS) pos_w = TW'(32'(pos) - MAX_TASKS);
      else pos_w = TW'(pos);
      push_addr = QW'(32'(push_lvl) * MAX_TASKS + 32'(pos_w));
   end

   always_ff @(posedge clock) begin
      if (st_ff == mfqs_pkg::ST_IDLE && accept_req) begin
         func_ff <= req.func;
         id_ff <= req.task_id;
         life_ff <= req.task_life;
         lvl_ff <= scan_lvl;
         any_ff <= scan_any;
         qrd_ff <= qmem[head_addr];
      end
      if (st_ff == mfqs_pkg::ST_READ) begin
         trd_ff <= tmem[qrd_ff];
         l4rd_ff <= l4mem[qrd_ff];
      end
      if (advance) begin
         if (do_push) qmem[push_addr] <= push_id;
         if (tw_en) begin
            tmem[tw_addr] <= tw_data;
            l4mem[tw_addr] <= (func_ff == mfqs_pkg::FUNC_ARRIVE) ? 8'd0 : l4_n;
         end
         oid_ff <= (func_ff == mfqs_pkg::FUNC_ARRIVE) ? id_ff :
                   (any_ff ? 4'(t) : 4'd0);
         olvl_ff <= (func_ff == mfqs_pkg::FUNC_TICK && any_ff) ?
                    {1'b0, lvl_ff} + 3'd1 : 3'd0;
         oev_ff <= ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= mfqs_pkg::ST_IDLE;
         rsp_v_ff <= 1'b0;
         act_ff <= '0;
         ptr_ff <= 3'd0;
         bud2_ff <= 8'd2;
         bud3_ff <= 8'd4;
         bud4_ff <= 8'd8;
         for (int k = 0; k < mfqs_pkg::NUM_LEVELS; k++) begin
            head_ff[k] <= '0;
            cnt_ff[k] <= '0;
         end
      end else begin
         if (csr_wr) begin
            case (csr_paddr[3:2])
               mfqs_pkg::REG_L2: bud2_ff <= csr_pwdata[7:0];
               mfqs_pkg::REG_L3: bud3_ff <= csr_pwdata[7:0];
               mfqs_pkg::REG_L4: bud4_ff <= csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (advance) rsp_v_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) rsp_v_ff <= 1'b0;
         case (st_ff)
            mfqs_pkg::ST_IDLE: begin
               if (accept_req) st_ff <= mfqs_pkg::ST_READ;
            end
            mfqs_pkg::ST_READ: st_ff <= mfqs_pkg::ST_OUT;
            mfqs_pkg::ST_OUT: begin
               if (advance) begin
                  st_ff <= mfqs_pkg::ST_IDLE;
                  if (func_ff == mfqs_pkg::FUNC_TICK) ptr_ff <= ptr_n;
                  if (id_ok) act_ff[TW'(id_ff)] <= 1'b1;
                  if (finished && func_ff == mfqs_pkg::FUNC_TICK && any_ff)
                     act_ff[t] <= 1'b0;
                  if (do_pop) begin
                     head_ff[lvl_ff] <= (32'(head_ff[lvl_ff]) == MAX_TASKS - 1) ?
                                        '0 : head_ff[lvl_ff] + TW'(1);
                  end
                  for (int k = 0; k < mfqs_pkg::NUM_LEVELS; k++) begin
                     cnt_ff[k] <= cnt_ff[k]
                        - CW'(do_pop && 2'(k) == lvl_ff)
                        + CW'(do_push && 2'(k) == push_lvl);
                  end
               end
            end
            default: st_ff <= mfqs_pkg::ST_IDLE;
         endcase
      end
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.served_id = oid_ff;
   assign rsp.served_level = olvl_ff;
   assign rsp.event_res = oev_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != mfqs_pkg::ST_IDLE |-> !req.ready) else $error("ready while busy");
   a_idle_level: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.event_res == mfqs_pkg::EV_IDLE |-> rsp.served_level == 3'd0)
      else $error("idle with level");
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= 3'd4) else $error("pointer range");
endmodule
`default_nettype wire

FILE: tb/multilevel_feedback_queue_scheduler_tb.sv
// Testbench for the four-level feedback queue scheduler: directed table, then random traffic.
`default_nettype none
module multilevel_feedback_queue_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TASKS = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 650;

   typedef struct packed {
      logic [3:0] served_id;
      logic [2:0] served_level;
      logic [2:0] event_res;
   } sched_result_type;

   typedef struct {
      logic [0:0]       func;
      logic [3:0]       task_id;
      logic [7:0]       task_life;
      bit               typed;
      sched_result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mfqs_req_if req ();
   mfqs_rsp_if rsp ();

   multilevel_feedback_queue_scheduler uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // scheduler mirror
   logic [3:0]    ring [4][TASKS];
   int            ring_head [4];
   int            ring_count [4];
   logic [7:0]    age [TASKS];
   logic [7:0]    lifetime [TASKS];
   logic [7:0]    slices_at [TASKS][3];
   bit            busy [TASKS];
   int            pointer;
   logic [7:0]    budget2, budget3, budget4;

   sched_result_type expected_results [$];
   int               errors;
   bit               typed_flag;
   sched_result_type typed_value;
   int               hold_cycles;
   int               cycle_count;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   task automatic ring_push(input int q, input logic [3:0] id);
      ring[q][(ring_head[q] + ring_count[q]) % TASKS] = id;
      ring_count[q]++;
   endtask

   task automatic ring_pop(input int q);
      ring_head[q] = (ring_head[q] + 1) % TASKS;
      ring_count[q]--;
   endtask

   task automatic schedule_step(input logic [0:0] f, input logic [3:0] id,
                                input logic [7:0] life, output sched_result_type r);
      int p, q, c;
      logic [3:0] t;
      bit higher;
      logic [7:0] lim;
      if (f == mfqs_pkg::FUNC_ARRIVE) begin
         r = '{id, 3'd0, mfqs_pkg::EV_DROPPED};
         if (!busy[id] && ring_count[0] < TASKS) begin
            ring_push(0, id);
            busy[id] = 1;
            age[id] = 0;
            lifetime[id] = life;
            for (int k = 0; k < 3; k++) slices_at[id][k] = 0;
            r.event_res = mfqs_pkg::EV_ACCEPTED;
         end
         return;
      end
      p = (pointer == 0) ? 1 : pointer;
      while (p <= mfqs_pkg::NUM_LEVELS && ring_count[p-1] == 0) p++;
      if (p > mfqs_pkg::NUM_LEVELS) begin
         pointer = 0;
         r = '{4'd0, 3'd0, mfqs_pkg::EV_IDLE};
         return;
      end
      pointer = p;
      q = p - 1;
      t = ring[q][ring_head[q]];
      age[t] = sat_inc(age[t]);
      c = 0;
      if (q >= 1) begin
         slices_at[t][q-1] = sat_inc(slices_at[t][q-1]);
         c = slices_at[t][q-1];
      end
      higher = 0;
      for (int k = 0; k < q; k++) if (ring_count[k] != 0) higher = 1;
      r.served_id = t;
      r.served_level = p[2:0];
      if (age[t] >= lifetime[t]) begin
         ring_pop(q);
         busy[t] = 0;
         r.event_res = mfqs_pkg::EV_FINISHED;
      end else if (q == 0) begin
         ring_pop(0);
         ring_push(1, t);
         r.event_res = mfqs_pkg::EV_DEMOTED;
      end else if (q < 3) begin
         lim = (q == 1) ? budget2 : budget3;
         if (c < lim) begin
            if (higher) begin
               ring_pop(q);
               ring_push(q, t);
               pointer = 1;
               r.event_res = mfqs_pkg::EV_PREEMPT;
            end else begin
               r.event_res = mfqs_pkg::EV_KEPT;
            end
         end else begin
            ring_pop(q);
            ring_push(q + 1, t);
            r.event_res = mfqs_pkg::EV_DEMOTED;
         end
      end else if (higher) begin
         ring_pop(q);
         ring_push(q, t);
         pointer = 1;
         r.event_res = mfqs_pkg::EV_PREEMPT;
      end else if (c >= budget4) begin
         ring_pop(q);
         ring_push(q, t);
         r.event_res = mfqs_pkg::EV_ROTATE;
      end else begin
         r.event_res = mfqs_pkg::EV_KEPT;
      end
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // result ready: random stall pattern with a changing stall rate, plus long holds
   initial begin
      int stall_pct;
      stall_pct = 0;
      rsp.ready = 0;
      forever begin
         @(negedge clock);
         if (cycle_count % 64 == 0) stall_pct = $urandom_range(0, 2) * 35;
         if (hold_cycles > 0) begin
            rsp.ready <= 0;
            hold_cycles--;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // acceptance and result checking
   always @(posedge clock) begin
      sched_result_type got, want, pred;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.served_id, rsp.served_level, rsp.event_res};
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: %p", got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.served_id !== want.served_id) begin
               $error("served_id expected %0d actual %0d", want.served_id, got.served_id);
               errors++;
            end
            if (got.served_level !== want.served_level) begin
               $error("served_level expected %0d actual %0d",
                      want.served_level, got.served_level);
               errors++;
            end
            if (got.event_res !== want.event_res) begin
               $error("event_res expected %0d actual %0d", want.event_res, got.event_res);
               errors++;
            end
         end
      end
      if (!reset && req.valid && req.ready) begin
         schedule_step(req.func, req.task_id, req.task_life, pred);
         expected_results.push_back(typed_flag ? typed_value : pred);
      end
   end

   task automatic write_budget(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         mfqs_pkg::REG_L2: budget2 = value;
         mfqs_pkg::REG_L3: budget3 = value;
         default: budget4 = value;
      endcase
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid <= 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // holds valid until the item is taken; valid stays high for the next call
   task automatic offer(input stim_row_type row);
      @(negedge clock);
      req.valid <= 1;
      req.func <= row.func;
      req.task_id <= row.task_id;
      req.task_life <= row.task_life;
      typed_flag <= row.typed;
      typed_value <= row.want;
      do @(posedge clock); while (!(req.valid && req.ready));
   endtask

   task automatic random_phase(input int count, input bit with_hold);
      stim_row_type row;
      int burst, gap;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               @(negedge clock);
               req.valid <= 0;
               repeat (gap - 1) @(negedge clock);
            end
            burst = $urandom_range(1, 12);
         end
         burst--;
         if (with_hold && n == count / 2) hold_cycles = 300;
         row.func = ($urandom_range(0, 99) < 60) ? mfqs_pkg::FUNC_TICK
                                                   : mfqs_pkg::FUNC_ARRIVE;
         row.task_id = 4'($urandom_range(0, TASKS - 1));
         row.task_life = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 24));
         row.typed = 0;
         row.want = '0;
         offer(row);
      end
      drain();
   endtask

   stim_row_type directed [] = '{
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   1, '{4'd0,  3'd0, mfqs_pkg::EV_IDLE}},
      '{mfqs_pkg::FUNC_ARRIVE, 4'd15, 8'd255, 1, '{4'd15, 3'd0, mfqs_pkg::EV_ACCEPTED}},
      '{mfqs_pkg::FUNC_ARRIVE, 4'd15, 8'd0,   1, '{4'd15, 3'd0, mfqs_pkg::EV_DROPPED}},
      '{mfqs_pkg::FUNC_ARRIVE, 4'd0,  8'd0,   1, '{4'd0,  3'd0, mfqs_pkg::EV_ACCEPTED}},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   1, '{4'd15, 3'd1, mfqs_pkg::EV_DEMOTED}},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   1, '{4'd0,  3'd1, mfqs_pkg::EV_FINISHED}},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   1, '{4'd15, 3'd2, mfqs_pkg::EV_KEPT}},
      '{mfqs_pkg::FUNC_ARRIVE, 4'd7,  8'd3,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_ARRIVE, 4'd10, 8'd170, 0, '0},
      '{mfqs_pkg::FUNC_ARRIVE, 4'd5,  8'd85,  0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0},
      '{mfqs_pkg::FUNC_TICK,   4'd0,  8'd0,   0, '0}
   };

   initial begin
      errors = 0;
      hold_cycles = 0;
      typed_flag = 0;
      typed_value = '0;
      reset = 1;
      req.valid = 0;
      req.func = mfqs_pkg::FUNC_ARRIVE;
      req.task_id = 0;
      req.task_life = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      for (int q = 0; q < 4; q++) begin
         ring_head[q] = 0;
         ring_count[q] = 0;
      end
      for (int i = 0; i < TASKS; i++) busy[i] = 0;
      pointer = 0;
      budget2 = 2;
      budget3 = 4;
      budget4 = 8;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (directed[i]) offer(directed[i]);
      drain();

      random_phase(130, 1);
      write_budget(mfqs_pkg::REG_L2, 8'd1);
      write_budget(mfqs_pkg::REG_L3, 8'd1);
      write_budget(mfqs_pkg::REG_L4, 8'd1);
      random_phase(130, 0);
      write_budget(mfqs_pkg::REG_L2, 8'd255);
      write_budget(mfqs_pkg::REG_L3, 8'd255);
      write_budget(mfqs_pkg::REG_L4, 8'd255);
      random_phase(130, 0);
      for (int ph = 0; ph < 2; ph++) begin
         write_budget(mfqs_pkg::REG_L2, 8'($urandom_range(1, 255)));
         write_budget(mfqs_pkg::REG_L3, 8'($urandom_range(1, 4)));
         write_budget(mfqs_pkg::REG_L4, 8'($urandom_range(1, 6)));
         random_phase(130, ph == 1);
      end

      repeat (20) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
design/mfqs_pkg.sv
design/mfqs_if.sv
design/multilevel_feedback_queue_scheduler.sv
tb/multilevel_feedback_queue_scheduler_tb.sv
